[src/frra_pkg.sv]
package frra_pkg;

    localparam int ROW_W   = 12;
    localparam int COL_W   = 9;
    localparam int ADDR_W  = 21;
    localparam int DIFF_W  = COL_W + 1;
    localparam int WGT_W   = 2 * COL_W;
    localparam int HMR_W   = ROW_W + 1;
    localparam int PROD_W  = 32;
    localparam int MAG_W   = PROD_W - 1;
    localparam int QUOT_W  = 11;
    localparam int SROW_W  = ROW_W + 2;

    localparam int unsigned SKEW_DIVISOR = 637729;
    localparam int          RECIP_SHIFT  = 40;
    localparam int          RECIP_W      = 21;
    localparam logic [RECIP_W-1:0] SKEW_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / SKEW_DIVISOR);
    localparam int SCALED_W = MAG_W + RECIP_W;

    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd0;
    localparam logic [1:0] REG_ROW_BYTES    = 2'd1;
    localparam logic [1:0] REG_CENTER_BYTE  = 2'd2;

    localparam logic [ROW_W-1:0] IMAGE_HEIGHT_RST = ROW_W'(1944);
    localparam logic [COL_W-1:0] ROW_BYTES_RST    = COL_W'(324);
    localparam logic [COL_W-1:0] CENTER_BYTE_RST  = COL_W'(162);

    typedef struct packed {
        logic [ROW_W-1:0] image_height;
        logic [COL_W-1:0] row_bytes;
        logic [COL_W-1:0] center_byte;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } coord_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic [ADDR_W-1:0]        dest;
    } prod_t;

    typedef struct packed {
        logic              neg;
        logic [QUOT_W-1:0] quot;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] dest;
    } quot_t;

endpackage

[src/frra_weight.sv]
module frra_weight
    import frra_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output prod_t  out_item
);

    logic                     s1_valid_reg;
    logic [WGT_W-1:0]         s1_weight_reg;
    logic [WGT_W-1:0]         s1_weight_next;
    logic signed [HMR_W-1:0]  s1_hmr_reg;
    logic signed [HMR_W-1:0]  s1_hmr_next;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [ADDR_W-1:0]        s1_dest_reg;
    logic [ADDR_W-1:0]        s1_dest_next;
    logic                     s2_valid_reg;
    prod_t                    s2_item_reg;
    prod_t                    s2_item_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [2*DIFF_W-1:0] square;
    logic                     en1;
    logic                     en2;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        diff           = $signed({1'b0, in_item.col}) - $signed({1'b0, cfg.center_byte});
        square         = diff * diff;
        s1_weight_next = WGT_W'(square);
        s1_hmr_next    = $signed({2'b00, cfg.image_height[ROW_W-1:1]})
                       - $signed({1'b0, in_item.row});
        s1_dest_next   = ADDR_W'(in_item.row) * ADDR_W'(cfg.row_bytes)
                       + ADDR_W'(in_item.col);
    end

    always_comb
    begin
        s2_item_next.prod = PROD_W'($signed({1'b0, s1_weight_reg})) * PROD_W'(s1_hmr_reg);
        s2_item_next.row  = s1_row_reg;
        s2_item_next.col  = s1_col_reg;
        s2_item_next.dest = s1_dest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_weight_reg <= s1_weight_next;
            s1_hmr_reg    <= s1_hmr_next;
            s1_row_reg    <= in_item.row;
            s1_col_reg    <= in_item.col;
            s1_dest_reg   <= s1_dest_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

[src/frra_divide.sv]
module frra_divide
    import frra_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output quot_t out_item
);

    logic                s3_valid_reg;
    logic                s3_neg_reg;
    logic [MAG_W-1:0]    s3_mag_reg;
    logic [MAG_W-1:0]    s3_mag_next;
    logic [QUOT_W-1:0]   s3_est_reg;
    logic [QUOT_W-1:0]   s3_est_next;
    logic [ROW_W-1:0]    s3_row_reg;
    logic [COL_W-1:0]    s3_col_reg;
    logic [ADDR_W-1:0]   s3_dest_reg;
    logic                s4_valid_reg;
    quot_t               s4_item_reg;
    quot_t               s4_item_next;
    logic [SCALED_W-1:0] scaled;
    logic [MAG_W-1:0]    est_times_div;
    logic [MAG_W-1:0]    remainder;
    logic                en3;
    logic                en4;

    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign in_ready = en3;

    // The reciprocal estimate is at most one below the true quotient.
    always_comb
    begin
        s3_mag_next = in_item.prod[PROD_W-1] ? MAG_W'(-in_item.prod) : MAG_W'(in_item.prod);
        scaled      = SCALED_W'(s3_mag_next) * SCALED_W'(SKEW_RECIP);
        s3_est_next = scaled[RECIP_SHIFT +: QUOT_W];
    end

    always_comb
    begin
        est_times_div     = MAG_W'(s3_est_reg) * MAG_W'(SKEW_DIVISOR);
        remainder         = s3_mag_reg - est_times_div;
        s4_item_next.neg  = s3_neg_reg;
        s4_item_next.quot = (remainder >= MAG_W'(SKEW_DIVISOR))
                          ? QUOT_W'(s3_est_reg + 1'b1) : s3_est_reg;
        s4_item_next.row  = s3_row_reg;
        s4_item_next.col  = s3_col_reg;
        s4_item_next.dest = s3_dest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                s3_valid_reg <= in_valid;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            s3_neg_reg  <= in_item.prod[PROD_W-1];
            s3_mag_reg  <= s3_mag_next;
            s3_est_reg  <= s3_est_next;
            s3_row_reg  <= in_item.row;
            s3_col_reg  <= in_item.col;
            s3_dest_reg <= in_item.dest;
        end
        if (en4 && s3_valid_reg)
        begin
            s4_item_reg <= s4_item_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

[src/frra_remap.sv]
module frra_remap
    import frra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  quot_t             in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_W-1:0]  source_row,
    output logic [ADDR_W-1:0] source_address,
    output logic [ADDR_W-1:0] dest_address,
    output logic              was_clamped
);

    logic                     s5_valid_reg;
    logic [ROW_W-1:0]         s5_src_reg;
    logic [ROW_W-1:0]         s5_src_next;
    logic                     s5_clamped_reg;
    logic                     s5_clamped_next;
    logic [COL_W-1:0]         s5_col_reg;
    logic [ADDR_W-1:0]        s5_dest_reg;
    logic                     s6_valid_reg;
    logic [ROW_W-1:0]         s6_src_reg;
    logic [ADDR_W-1:0]        s6_src_addr_reg;
    logic [ADDR_W-1:0]        s6_src_addr_next;
    logic [ADDR_W-1:0]        s6_dest_reg;
    logic                     s6_clamped_reg;
    logic signed [SROW_W-1:0] delta;
    logic signed [SROW_W-1:0] raw_row;
    logic [ROW_W-1:0]         upper_row;
    logic                     en5;
    logic                     en6;

    assign en6      = !s6_valid_reg || out_ready;
    assign en5      = !s5_valid_reg || en6;
    assign in_ready = en5;

    always_comb
    begin
        delta     = in_item.neg ? -$signed({3'b000, in_item.quot})
                                : $signed({3'b000, in_item.quot});
        raw_row   = $signed({2'b00, in_item.row}) + delta;
        upper_row = (cfg.image_height == '0) ? '0 : cfg.image_height - 1'b1;
        if (raw_row[SROW_W-1])
        begin
            s5_src_next     = '0;
            s5_clamped_next = 1'b1;
        end
        else if (raw_row[SROW_W-2:0] >= {1'b0, cfg.image_height})
        begin
            s5_src_next     = upper_row;
            s5_clamped_next = 1'b1;
        end
        else
        begin
            s5_src_next     = raw_row[ROW_W-1:0];
            s5_clamped_next = 1'b0;
        end
    end

    assign s6_src_addr_next = ADDR_W'(s5_src_reg) * ADDR_W'(cfg.row_bytes)
                            + ADDR_W'(s5_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (en5)
            begin
                s5_valid_reg <= in_valid;
            end
            if (en6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5 && in_valid)
        begin
            s5_src_reg     <= s5_src_next;
            s5_clamped_reg <= s5_clamped_next;
            s5_col_reg     <= in_item.col;
            s5_dest_reg    <= in_item.dest;
        end
        if (en6 && s5_valid_reg)
        begin
            s6_src_reg      <= s5_src_reg;
            s6_src_addr_reg <= s6_src_addr_next;
            s6_dest_reg     <= s5_dest_reg;
            s6_clamped_reg  <= s5_clamped_reg;
        end
    end

    assign out_valid      = s6_valid_reg;
    assign source_row     = s6_src_reg;
    assign source_address = s6_src_addr_reg;
    assign dest_address   = s6_dest_reg;
    assign was_clamped    = s6_clamped_reg;

endmodule

[src/fisheye_row_remap_address_unit.sv]
// Six register stages, s1 to s6: a beat accepted into s1 passes through stages s2 to s5
// in order and is then held in s6, the output register, until out_ready takes it.
// Throughput is one beat per cycle; each stage moves on when its successor has room.
// The weight multiply, reciprocal divide and remap clamp submodules make up that depth.
// Reset clears all valid bits and loads the configuration registers with
// image_height 1944, row_bytes 324 and center_byte 162.
module fisheye_row_remap_address_unit
    import frra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [ROW_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ROW_W-1:0]  out_row,
    input  logic [COL_W-1:0]  out_col_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_W-1:0]  source_row,
    output logic [ADDR_W-1:0] source_address,
    output logic [ADDR_W-1:0] dest_address,
    output logic              was_clamped
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    coord_t in_item;
    logic   wgt_valid;
    logic   wgt_ready;
    prod_t  wgt_item;
    logic   div_valid;
    logic   div_ready;
    quot_t  div_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                REG_ROW_BYTES:    cfg_next.row_bytes    = cfg_data[COL_W-1:0];
                REG_CENTER_BYTE:  cfg_next.center_byte  = cfg_data[COL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.row_bytes    <= ROW_BYTES_RST;
            cfg_reg.center_byte  <= CENTER_BYTE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item.row = out_row;
    assign in_item.col = out_col_byte;

    frra_weight u_weight
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (wgt_valid),
        .out_ready (wgt_ready),
        .out_item  (wgt_item)
    );

    frra_divide u_divide
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wgt_valid),
        .in_ready  (wgt_ready),
        .in_item   (wgt_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    frra_remap u_remap
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .in_item        (div_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .source_row     (source_row),
        .source_address (source_address),
        .dest_address   (dest_address),
        .was_clamped    (was_clamped)
    );

endmodule
